@@ hw/rtl/pscaw_pkg.sv @@
// Shared types and constants of the PI speed controller with anti-windup.
// Holds field widths, register codes, reset values and the structs that
// travel between the controller's modules. Depends on nothing.
package pscaw_pkg;

    localparam int unsigned SPEED_W    = 24;                  // Q16.8 RPM, unsigned
    localparam int unsigned ERR_W      = SPEED_W + 1;         // signed speed error
    localparam int unsigned INTEG_W    = 40;                  // signed integrator
    localparam int unsigned GAIN_W     = 16;                  // unsigned Q8.8 gains
    localparam int unsigned DUTY_W     = 15;                  // PWM ticks
    localparam int unsigned FRAC_BITS  = 16;                  // drive fraction bits
    localparam int unsigned P_TERM_W   = GAIN_W + ERR_W;      // gain * error
    localparam int unsigned I_TERM_W   = GAIN_W + INTEG_W;    // gain * integrator
    localparam int unsigned DRIVE_W    = I_TERM_W + 1;        // sum of both terms
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN  = 2'd0,
        CFG_INTEG_GAIN = 2'd1,
        CFG_DUTY_MIN   = 2'd2,
        CFG_DUTY_MAX   = 2'd3
    } t_cfg_idx;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd16640;  // 65.0
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd512;    // 2.0
    localparam logic [DUTY_W-1:0] DUTY_MIN_RST   = 15'd0;
    localparam logic [DUTY_W-1:0] DUTY_MAX_RST   = 15'd32767;

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integ_gain;
        logic [DUTY_W-1:0] duty_min;
        logic [DUTY_W-1:0] duty_max;
    } t_cfg;

    typedef struct packed {
        logic [DUTY_W-1:0]         duty;
        logic                      clamped;
        logic                      held;
        logic signed [INTEG_W-1:0] acc_next;
    } t_pi_result;

    typedef struct packed {
        logic                      en;
        logic                      ch;
        logic signed [INTEG_W-1:0] acc;
    } t_integ_wr;

endpackage

@@ hw/rtl/pscaw_cfg_regs.sv @@
// Configuration register file of the PI speed controller: gains and limits.
// Depends on pscaw_pkg for register codes, widths and reset values.
module pscaw_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_en,
    input  logic [pscaw_pkg::CFG_IDX_W-1:0]     i_wr_index,
    input  logic [pscaw_pkg::CFG_DATA_W-1:0]    i_wr_data,
    output pscaw_pkg::t_cfg                     o_cfg
);

    pscaw_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain  <= pscaw_pkg::PROP_GAIN_RST;
            r_cfg.integ_gain <= pscaw_pkg::INTEG_GAIN_RST;
            r_cfg.duty_min   <= pscaw_pkg::DUTY_MIN_RST;
            r_cfg.duty_max   <= pscaw_pkg::DUTY_MAX_RST;
        end else if (i_wr_en) begin
            case (pscaw_pkg::t_cfg_idx'(i_wr_index))
                pscaw_pkg::CFG_PROP_GAIN: begin
                    r_cfg.prop_gain <= i_wr_data[pscaw_pkg::GAIN_W-1:0];
                end
                pscaw_pkg::CFG_INTEG_GAIN: begin
                    r_cfg.integ_gain <= i_wr_data[pscaw_pkg::GAIN_W-1:0];
                end
                pscaw_pkg::CFG_DUTY_MIN: begin
                    r_cfg.duty_min <= i_wr_data[pscaw_pkg::DUTY_W-1:0];
                end
                pscaw_pkg::CFG_DUTY_MAX: begin
                    r_cfg.duty_max <= i_wr_data[pscaw_pkg::DUTY_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/pscaw_integ_bank.sv @@
// Per-channel error integrators of the PI speed controller, cleared by reset.
// One read port and one write port; depends on pscaw_pkg for widths and types.
module pscaw_integ_bank #(
    parameter int NUM_CHANNELS = 2
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_rd_ch,
    output logic                                    o_rd_in_range,
    output logic signed [pscaw_pkg::INTEG_W-1:0]    o_rd_acc,
    input  pscaw_pkg::t_integ_wr                    i_wr
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic signed [pscaw_pkg::INTEG_W-1:0] r_acc [NUM_CHANNELS];
    logic [CH_W-1:0] rd_idx;
    logic [CH_W-1:0] wr_idx;

    assign rd_idx        = CH_W'(i_rd_ch);
    assign wr_idx        = CH_W'(i_wr.ch);
    assign o_rd_in_range = (int'(rd_idx) < NUM_CHANNELS);
    assign o_rd_acc      = o_rd_in_range ? r_acc[rd_idx] : '0;

    for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_ch
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_acc[g] <= '0;
            end else if (i_wr.en && (wr_idx == CH_W'(g))) begin
                r_acc[g] <= i_wr.acc;
            end
        end
    end

endmodule

@@ hw/rtl/pscaw_pi_datapath.sv @@
// Single-pass PI arithmetic: error, saturating integration, drive, clamp
// and the anti-windup decision. Purely combinational; depends on pscaw_pkg.
module pscaw_pi_datapath (
    input  pscaw_pkg::t_cfg                         i_cfg,
    input  logic [pscaw_pkg::SPEED_W-1:0]           i_target_speed,
    input  logic [pscaw_pkg::SPEED_W-1:0]           i_measured_speed,
    input  logic signed [pscaw_pkg::INTEG_W-1:0]    i_acc_old,
    output pscaw_pkg::t_pi_result                   o_res
);

    localparam int unsigned HI_PAD = pscaw_pkg::DRIVE_W - pscaw_pkg::DUTY_W
                                     - pscaw_pkg::FRAC_BITS;

    logic signed [pscaw_pkg::ERR_W-1:0]     err;
    logic signed [pscaw_pkg::INTEG_W:0]     acc_sum;
    logic signed [pscaw_pkg::INTEG_W-1:0]   acc_sat;
    logic signed [pscaw_pkg::P_TERM_W-1:0]  p_term;
    logic signed [pscaw_pkg::I_TERM_W-1:0]  i_term;
    logic signed [pscaw_pkg::DRIVE_W-1:0]   drive;
    logic signed [pscaw_pkg::DRIVE_W-1:0]   hi_lim;
    logic signed [pscaw_pkg::DRIVE_W-1:0]   lo_lim;
    logic                                   above;
    logic                                   below;
    logic                                   err_pos;
    logic                                   err_neg;

    assign err = $signed({1'b0, i_target_speed}) - $signed({1'b0, i_measured_speed});

    // Saturate the integrator at its signed 40-bit limits.
    assign acc_sum = (pscaw_pkg::INTEG_W+1)'(i_acc_old) + (pscaw_pkg::INTEG_W+1)'(err);
    always_comb begin
        if (acc_sum[pscaw_pkg::INTEG_W] != acc_sum[pscaw_pkg::INTEG_W-1]) begin
            acc_sat = acc_sum[pscaw_pkg::INTEG_W] ? pscaw_pkg::INTEG_MIN
                                                  : pscaw_pkg::INTEG_MAX;
        end else begin
            acc_sat = acc_sum[pscaw_pkg::INTEG_W-1:0];
        end
    end

    assign p_term = pscaw_pkg::P_TERM_W'($signed({1'b0, i_cfg.prop_gain}))
                  * pscaw_pkg::P_TERM_W'(err);
    assign i_term = pscaw_pkg::I_TERM_W'($signed({1'b0, i_cfg.integ_gain}))
                  * pscaw_pkg::I_TERM_W'(acc_sat);
    assign drive  = pscaw_pkg::DRIVE_W'(p_term) + pscaw_pkg::DRIVE_W'(i_term);

    assign hi_lim = $signed({{HI_PAD{1'b0}}, i_cfg.duty_max, {pscaw_pkg::FRAC_BITS{1'b0}}});
    assign lo_lim = $signed({{HI_PAD{1'b0}}, i_cfg.duty_min, {pscaw_pkg::FRAC_BITS{1'b0}}});

    assign above   = (drive > hi_lim);
    assign below   = (drive < lo_lim);
    assign err_neg = err[pscaw_pkg::ERR_W-1];
    assign err_pos = !err_neg && (err != '0);

    // High limit wins when the limits cross; anti-windup follows the same order.
    always_comb begin
        o_res.clamped = 1'b0;
        o_res.held    = 1'b0;
        if (above) begin
            o_res.duty    = i_cfg.duty_max;
            o_res.clamped = 1'b1;
            o_res.held    = err_pos;
        end else if (below) begin
            o_res.duty    = i_cfg.duty_min;
            o_res.clamped = 1'b1;
            o_res.held    = err_neg;
        end else begin
            o_res.duty = drive[pscaw_pkg::FRAC_BITS +: pscaw_pkg::DUTY_W];
        end
        o_res.acc_next = o_res.held ? i_acc_old : acc_sat;
    end

endmodule

@@ hw/rtl/pi_speed_controller_antiwindup.sv @@
// Top level of the two-channel PI speed controller with anti-windup.
// Instantiates pscaw_cfg_regs, pscaw_integ_bank and pscaw_pi_datapath; uses pscaw_pkg.

// Each input word names a motor channel and carries target and measured speed
// (unsigned Q16.8 RPM). The block forms the signed error, adds it to that
// channel's 40-bit saturating integrator, computes prop_gain*error plus
// integ_gain_per_step*integrator (Q8.8 gains, 16 fraction bits in the drive),
// clamps to [duty_min, duty_max] or truncates to whole PWM ticks, and drops
// the integration step when the drive is pinned at a limit in the direction
// of the error. The design is a two-register pipeline: an input register,
// then one pass of arithmetic (one subtract, two adds, two multipliers, two
// compares) into the result register, with the integrator written back in
// that same cycle. Throughput is one word per clock when i_out_stall is low,
// including back-to-back words on the same channel; an accepted word goes
// through the input register, then the result register, and is taken there.
// The input register keeps accepting while a finished result is stalled, so
// o_in_stall rises only when both registers are full and i_out_stall is high.
// Words for a channel at or above NUM_CHANNELS leave no result and no state.
// Configuration writes are always taken (o_cfg_ready stays high) and
// are expected only while the pipeline is empty. Reset clears all integrators.
module pi_speed_controller_antiwindup #(
    parameter int NUM_CHANNELS = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input word channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_channel,
    input  logic [pscaw_pkg::SPEED_W-1:0]       i_target_speed,
    input  logic [pscaw_pkg::SPEED_W-1:0]       i_measured_speed,
    // result word channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_channel_out,
    output logic [pscaw_pkg::DUTY_W-1:0]        o_duty_ticks,
    output logic                                o_clamped,
    output logic                                o_integration_held,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pscaw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pscaw_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    pscaw_pkg::t_cfg        cfg;
    pscaw_pkg::t_pi_result  res;
    pscaw_pkg::t_integ_wr   integ_wr;

    // Input register
    logic                               r_s1_valid;
    logic                               r_s1_channel;
    logic [pscaw_pkg::SPEED_W-1:0]      r_s1_target;
    logic [pscaw_pkg::SPEED_W-1:0]      r_s1_measured;

    // Result register
    logic                               r_out_valid;
    logic                               r_out_channel;
    logic [pscaw_pkg::DUTY_W-1:0]       r_out_duty;
    logic                               r_out_clamped;
    logic                               r_out_held;

    logic                                   in_range;
    logic signed [pscaw_pkg::INTEG_W-1:0]   acc_old;
    logic                                   out_free;
    logic                                   s1_advance;
    logic                                   s1_emit;
    logic                                   in_accept;

    // Configuration is always ready: each write goes straight into its register.
    assign o_cfg_ready = 1'b1;

    pscaw_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    pscaw_integ_bank #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_integ (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rd_ch       (r_s1_channel),
        .o_rd_in_range (in_range),
        .o_rd_acc      (acc_old),
        .i_wr          (integ_wr)
    );

    pscaw_pi_datapath u_dp (
        .i_cfg            (cfg),
        .i_target_speed   (r_s1_target),
        .i_measured_speed (r_s1_measured),
        .i_acc_old        (acc_old),
        .o_res            (res)
    );

    // Handshake: the result register is free when empty or being taken.
    // An out-of-range word drops without needing the result register.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_advance = r_s1_valid && (!in_range || out_free);
    assign s1_emit    = s1_advance && in_range;
    assign o_in_stall = r_s1_valid && !s1_advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Commit the integrator only when the word's result moves on.
    assign integ_wr.en  = s1_emit;
    assign integ_wr.ch  = r_s1_channel;
    assign integ_wr.acc = res.acc_next;

    // Input register: load on accept, otherwise empty once the word advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_channel  <= i_channel;
            r_s1_target   <= i_target_speed;
            r_s1_measured <= i_measured_speed;
        end
    end

    // Result register: load a new result, or drop the taken one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_emit) begin
            r_out_channel <= r_s1_channel;
            r_out_duty    <= res.duty;
            r_out_clamped <= res.clamped;
            r_out_held    <= res.held;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_channel_out      = r_out_channel;
    assign o_duty_ticks       = r_out_duty;
    assign o_clamped          = r_out_clamped;
    assign o_integration_held = r_out_held;

endmodule

@@ hw/rtl/pscaw_checker.sv @@
// Port-level checker for the PI speed controller and its bind to the top.
// Depends on pscaw_pkg for field widths.
module pscaw_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_in_stall,
    input  logic                            o_out_valid,
    input  logic                            i_out_stall,
    input  logic                            o_channel_out,
    input  logic [pscaw_pkg::DUTY_W-1:0]    o_duty_ticks,
    input  logic                            o_clamped,
    input  logic                            o_integration_held
);

    // Hold a stalled result word unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_channel_out)
            && $stable(o_duty_ticks) && $stable(o_clamped)
            && $stable(o_integration_held))
        else $error("stalled result word changed");

    // Anti-windup acts only on a clamped drive.
    a_held_needs_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_clamped |-> !o_integration_held)
        else $error("integration held without clamping");

    // Back-pressure the input only when the result side is full and stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while result side was free");

    // Come out of reset with no result pending.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind pi_speed_controller_antiwindup pscaw_checker u_pscaw_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_in_stall         (o_in_stall),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_channel_out      (o_channel_out),
    .o_duty_ticks       (o_duty_ticks),
    .o_clamped          (o_clamped),
    .o_integration_held (o_integration_held)
);

@@ tb/pscaw_drive_checker.sv @@
// Scoreboard for the PI speed controller: watches the input, result and
// configuration channels, predicts every drive word and compares it field
// by field. Depends on pscaw_pkg.
module pscaw_drive_checker
    import pscaw_pkg::*;
#(
    parameter int NUM_CHANNELS = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic                  i_channel,
    input  logic [SPEED_W-1:0]    i_target_speed,
    input  logic [SPEED_W-1:0]    i_measured_speed,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic                  i_channel_out,
    input  logic [DUTY_W-1:0]     i_duty_ticks,
    input  logic                  i_clamped,
    input  logic                  i_integration_held,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending_words
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ACC_HI = longint'(INTEG_MAX);
    localparam longint ACC_LO = longint'(INTEG_MIN);

    typedef struct packed {
        logic              ch;
        logic [DUTY_W-1:0] duty;
        logic              clamped;
        logic              held;
    } drive_word_t;

    drive_word_t       drive_expect_q[$];
    logic [GAIN_W-1:0] kp_reg;
    logic [GAIN_W-1:0] ki_reg;
    logic [DUTY_W-1:0] dmin_reg;
    logic [DUTY_W-1:0] dmax_reg;
    longint            integ_model[NUM_CHANNELS];
    int                fail_count = 0;
    int                pending_words = 0;

    assign o_fail_count    = fail_count;
    assign o_pending_words = pending_words;

    task automatic check_field(input string field, input longint expected,
                               input longint actual);
        if (expected != actual) begin
            $error("%s mismatch: expected %0d, got %0d", field, expected, actual);
            fail_count++;
        end
    endtask

    // Integrate the error, form the drive, clamp it and undo the step when
    // the drive is pinned in the direction of the error.
    function automatic drive_word_t predict_drive(input logic ch,
                                                  input logic [SPEED_W-1:0] tgt,
                                                  input logic [SPEED_W-1:0] meas);
        longint      err;
        longint      prior;
        longint      acc;
        longint      drive;
        longint      hi;
        longint      lo;
        drive_word_t w;
        err   = longint'(tgt) - longint'(meas);
        prior = integ_model[ch];
        acc   = prior + err;
        if (acc > ACC_HI) begin
            acc = ACC_HI;
        end else if (acc < ACC_LO) begin
            acc = ACC_LO;
        end
        drive = longint'(kp_reg) * err + longint'(ki_reg) * acc;
        hi    = longint'(dmax_reg) <<< FRAC_BITS;
        lo    = longint'(dmin_reg) <<< FRAC_BITS;
        w.ch      = ch;
        w.clamped = 1'b0;
        w.held    = 1'b0;
        // high limit first, so crossed limits resolve the same way
        if (drive > hi) begin
            w.duty    = dmax_reg;
            w.clamped = 1'b1;
            w.held    = (err > 0);
        end else if (drive < lo) begin
            w.duty    = dmin_reg;
            w.clamped = 1'b1;
            w.held    = (err < 0);
        end else begin
            w.duty = DUTY_W'(drive >>> FRAC_BITS);
        end
        integ_model[ch] = w.held ? prior : acc;
        return w;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        drive_word_t want;
        if (!i_rst_n) begin
            kp_reg   = PROP_GAIN_RST;
            ki_reg   = INTEG_GAIN_RST;
            dmin_reg = DUTY_MIN_RST;
            dmax_reg = DUTY_MAX_RST;
            foreach (integ_model[c]) integ_model[c] = 0;
            drive_expect_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_PROP_GAIN:  kp_reg   = i_cfg_data;
                    CFG_INTEG_GAIN: ki_reg   = i_cfg_data;
                    CFG_DUTY_MIN:   dmin_reg = i_cfg_data[DUTY_W-1:0];
                    CFG_DUTY_MAX:   dmax_reg = i_cfg_data[DUTY_W-1:0];
                    default: ;
                endcase
            end
            // compare before pushing: a word taken this edge cannot leave yet
            if (i_out_valid && !i_out_stall) begin
                if (drive_expect_q.size() == 0) begin
                    $error("result word with nothing pending: channel %0d duty %0d",
                           i_channel_out, i_duty_ticks);
                    fail_count++;
                end else begin
                    want = drive_expect_q.pop_front();
                    check_field("channel_out", want.ch, i_channel_out);
                    check_field("duty_ticks", want.duty, i_duty_ticks);
                    check_field("clamped", want.clamped, i_clamped);
                    check_field("integration_held", want.held, i_integration_held);
                end
            end
            if (i_in_valid && !i_in_stall && i_channel < NUM_CHANNELS) begin
                drive_expect_q.push_back(
                    predict_drive(i_channel, i_target_speed, i_measured_speed));
            end
        end
        pending_words = drive_expect_q.size();
    end

endmodule

@@ tb/testbench.sv @@
// Top of the PI speed controller testbench: clock, reset, stimulus and the
// final verdict. Depends on pscaw_pkg, pscaw_drive_checker and the block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pscaw_pkg::*;

    localparam int IDLE_PCT        = 27;
    localparam int RX_HOLD_CYCLES  = 200;
    localparam int SETTLE_CYCLES   = 4;
    localparam int RANDOM_PHASES   = 8;
    localparam int WORDS_PER_PHASE = 106;
    localparam logic [SPEED_W-1:0] SPEED_FULL = '1;
    localparam logic [SPEED_W-1:0] SPEED_ZERO = '0;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  in_channel = 1'b0;
    logic [SPEED_W-1:0]    target_speed = '0;
    logic [SPEED_W-1:0]    measured_speed = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  channel_out;
    logic [DUTY_W-1:0]     duty_ticks;
    logic                  clamped;
    logic                  integration_held;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    t_cfg_idx              cfg_index = CFG_PROP_GAIN;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    fail_count;
    int                    pending_words;

    // stimulus knobs shared between the sender and the receiver process
    bit tx_idle_on  = 1'b1;
    bit rx_idle_on  = 1'b1;
    bit rx_hold_req = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pi_speed_controller_antiwindup #(
        .NUM_CHANNELS(2)
    ) dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_channel          (in_channel),
        .i_target_speed     (target_speed),
        .i_measured_speed   (measured_speed),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_channel_out      (channel_out),
        .o_duty_ticks       (duty_ticks),
        .o_clamped          (clamped),
        .o_integration_held (integration_held),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data)
    );

    pscaw_drive_checker #(
        .NUM_CHANNELS(2)
    ) drive_check (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_stall         (in_stall),
        .i_channel          (in_channel),
        .i_target_speed     (target_speed),
        .i_measured_speed   (measured_speed),
        .i_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .i_channel_out      (channel_out),
        .i_duty_ticks       (duty_ticks),
        .i_clamped          (clamped),
        .i_integration_held (integration_held),
        .i_cfg_valid        (cfg_valid),
        .i_cfg_ready        (cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .o_fail_count       (fail_count),
        .o_pending_words    (pending_words)
    );

    // Result side: stall at random, or hold the channel shut for a long
    // stretch on request so both pipeline registers fill and the input stalls.
    always begin
        @(posedge clk);
        if (rx_hold_req) begin
            out_stall <= 1'b1;
            repeat (RX_HOLD_CYCLES) @(posedge clk);
            rx_hold_req = 1'b0;
        end else begin
            out_stall <= rx_idle_on && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Hard stop in case the block stops answering.
    initial begin
        #10ms;
        $display("Some tests failed");
        $finish;
    end

    // Offer one word; called in the time step of a rising edge. Valid stays
    // high into the next word unless an idle cycle is drawn, so it is never
    // dropped and raised within one step.
    task automatic offer_speed_word(input logic ch, input logic [SPEED_W-1:0] tgt,
                                    input logic [SPEED_W-1:0] meas);
        while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        in_channel     <= ch;
        target_speed   <= tgt;
        measured_speed <= meas;
        do @(posedge clk); while (in_stall);
    endtask

    // Express a signed speed error as a target/measured pair.
    task automatic offer_error_word(input logic ch, input longint err_val);
        if (err_val < 0) begin
            offer_speed_word(ch, SPEED_ZERO, SPEED_W'(-err_val));
        end else begin
            offer_speed_word(ch, SPEED_W'(err_val), SPEED_ZERO);
        end
    endtask

    // Mostly near-balanced speeds so the drive often lands inside the
    // limits; the rest spans the full range.
    task automatic offer_random_word();
        logic [SPEED_W-1:0] meas;
        longint             delta;
        longint             tgt;
        int                 pick;
        pick = $urandom_range(99);
        meas = SPEED_W'($urandom());
        if (pick < 55) begin
            delta = longint'($urandom_range(8191)) - 4096;
        end else if (pick < 80) begin
            delta = longint'($urandom_range(262143)) - 131072;
        end else begin
            delta = longint'($urandom_range(16777215)) - longint'(meas);
        end
        tgt = longint'(meas) + delta;
        if (tgt < 0) begin
            tgt = 0;
        end else if (tgt > longint'(SPEED_FULL)) begin
            tgt = longint'(SPEED_FULL);
        end
        offer_speed_word(1'($urandom_range(1)), SPEED_W'(tgt), meas);
    endtask

    // Drop valid, wait for every predicted word to come back, then let the
    // pipeline run idle for SETTLE_CYCLES before touching the registers.
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_words != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Valid is left high; the caller lowers it after the last write.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic load_config(input logic [CFG_DATA_W-1:0] kp,
                               input logic [CFG_DATA_W-1:0] ki,
                               input logic [CFG_DATA_W-1:0] dmin,
                               input logic [CFG_DATA_W-1:0] dmax);
        write_reg(CFG_PROP_GAIN, kp);
        write_reg(CFG_INTEG_GAIN, ki);
        write_reg(CFG_DUTY_MIN, dmin);
        write_reg(CFG_DUTY_MAX, dmax);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [GAIN_W-1:0] random_gain();
        case ($urandom_range(3))
            0: return GAIN_W'($urandom_range(65535));
            1: return GAIN_W'($urandom_range(4095));
            2: return GAIN_W'($urandom_range(255));
            default: return GAIN_W'($urandom_range(31));
        endcase
    endfunction

    // Random gains and limits; the unused top bit of the limit data is
    // random too and must be dropped by the block.
    task automatic load_random_config(input bit crossed);
        logic [DUTY_W-1:0] a;
        logic [DUTY_W-1:0] b;
        logic [DUTY_W-1:0] lo;
        logic [DUTY_W-1:0] hi;
        a  = DUTY_W'($urandom_range(32767));
        b  = DUTY_W'($urandom_range(32767));
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        load_config(random_gain(), random_gain(),
                    {1'($urandom_range(1)), crossed ? hi : lo},
                    {1'($urandom_range(1)), crossed ? lo : hi});
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset gains: zero error, full positive and negative error (pinned
        // at a limit and held), a small in-range drive.
        offer_error_word(1'b0, 0);
        offer_speed_word(1'b0, SPEED_FULL, SPEED_ZERO);
        offer_speed_word(1'b1, SPEED_ZERO, SPEED_FULL);
        offer_error_word(1'b1, 256);
        offer_speed_word(1'b0, SPEED_FULL, SPEED_FULL);
        settle();

        // Unit proportional gain makes the drive equal the error: hit each
        // limit exactly, one fraction above the top, one below the bottom
        // with a positive error (clamped, not held), and truncation.
        load_config(16'd1, 16'd0, 16'd10, 16'd100);
        offer_error_word(1'b0, 6553600);
        offer_error_word(1'b0, 6553601);
        offer_error_word(1'b1, 655360);
        offer_error_word(1'b1, 655359);
        offer_error_word(1'b0, 655360 + 65535);
        offer_error_word(1'b1, -1);
        settle();

        // Crossed limits: the top is tested first, everything else lands on
        // the bottom limit.
        load_config(16'd1, 16'd0, 16'd200, 16'd100);
        offer_error_word(1'b0, 0);
        offer_error_word(1'b0, -5);
        offer_speed_word(1'b1, SPEED_FULL, SPEED_ZERO);
        offer_error_word(1'b1, 6553600);
        settle();

        // Integrator alone pins the drive high: a negative error keeps
        // integrating, a positive one is held.
        load_config(16'd0, 16'hFFFF, 16'd0, 16'd32767);
        offer_error_word(1'b0, -1);
        offer_error_word(1'b0, 1);
        settle();

        // Largest register data, both limits at the top.
        load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        offer_speed_word(1'b1, SPEED_FULL, SPEED_ZERO);
        offer_speed_word(1'b0, SPEED_ZERO, SPEED_FULL);
        settle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: load_config(16'hFFFF, 16'hFFFF, 16'h0000, 16'h7FFF);
                1: load_config(16'h0000, 16'h0000, 16'h0000, 16'h0000);
                2: load_random_config(1'b1);
                default: load_random_config(1'b0);
            endcase
            // one phase runs with no idling on either side
            tx_idle_on = (phase != 3);
            rx_idle_on = (phase != 3);
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                // back-pressure: shut the result side and keep offering
                if (phase == 5 && n == 10) begin
                    rx_hold_req = 1'b1;
                    tx_idle_on  = 1'b0;
                end
                if (phase == 5 && n == 60) begin
                    tx_idle_on = 1'b1;
                end
                offer_random_word();
            end
            settle();
        end

        // Read the integrators back through a unit integral gain, then push
        // each one further in both directions at full-scale error.
        load_config(16'd0, 16'd1, 16'd0, 16'h7FFF);
        offer_error_word(1'b0, 0);
        offer_error_word(1'b1, 0);
        offer_speed_word(1'b0, SPEED_FULL, SPEED_ZERO);
        offer_speed_word(1'b1, SPEED_ZERO, SPEED_FULL);
        offer_speed_word(1'b0, SPEED_ZERO, SPEED_FULL);
        offer_speed_word(1'b1, SPEED_FULL, SPEED_ZERO);
        settle();

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
